// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLWS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CLWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clws_pkg.sv
// Types, constants and control store for the character LCD write sequencer.
`default_nettype none

package clws_pkg;

    localparam int IN_DATA_W   = 48;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PC_W        = 5;
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_IDX_W = 4;
    localparam int QUOT_W      = 29;

    localparam logic [7:0]  RST_PULSE_US     = 8'd10;
    localparam logic [15:0] RST_SETTLE_US    = 16'd2000;
    localparam logic [7:0]  RST_FS_CMD       = 8'h38;
    localparam logic [7:0]  RST_DC_CMD       = 8'h0C;
    localparam logic [7:0]  CMD_CLEAR        = 8'h01;
    localparam logic [15:0] POWER_UP_WAIT_US = 16'd40000;
    localparam logic [15:0] INIT_GAP_US      = 16'd100;
    localparam logic [31:0] DIV10_RECIP      = 32'hCCCCCCCD;
    localparam logic [3:0]  ASCII_DIGIT_HI   = 4'h3;
    localparam logic [1:0]  ROW0_BASE_HI     = 2'b10;
    localparam logic [1:0]  ROW1_BASE_HI     = 2'b11;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_SET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL   = 2'd3;

    localparam logic [PC_W-1:0] PC_INIT      = 5'd0;
    localparam logic [PC_W-1:0] PC_WR_DATA   = 5'd10;
    localparam logic [PC_W-1:0] PC_WR_CMD    = 5'd12;
    localparam logic [PC_W-1:0] PC_SET_POS   = 5'd14;
    localparam logic [PC_W-1:0] PC_DATA_POS  = 5'd16;
    localparam logic [PC_W-1:0] PC_NUMBER    = 5'd18;
    localparam logic [PC_W-1:0] PC_NUM_DIGIT = 5'd19;
    localparam logic [PC_W-1:0] PC_NUM_EMIT  = 5'd20;

    typedef enum logic [2:0] {
        ACT_INIT      = 3'd0,
        ACT_WR_DATA   = 3'd1,
        ACT_WR_CMD    = 3'd2,
        ACT_SET_POS   = 3'd3,
        ACT_DATA_POS  = 3'd4,
        ACT_NUMBER    = 3'd5
    } t_action;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef enum logic [1:0] {
        OP_PHASE,
        OP_MUL,
        OP_DIGIT
    } t_op;

    typedef enum logic [2:0] {
        SRC_HELD,
        SRC_FS,
        SRC_DC,
        SRC_CLR,
        SRC_DATA,
        SRC_POS,
        SRC_DIGIT
    } t_src;

    typedef enum logic [1:0] {
        HOLD_POWER,
        HOLD_GAP,
        HOLD_PULSE,
        HOLD_SETTLE
    } t_hold;

    typedef enum logic [1:0] {
        CD_NONE,
        CD_QUOT_NZ,
        CD_IDX_NZ
    } t_cond;

    typedef struct packed {
        t_op             op;
        logic            en;
        logic            rs;
        t_src            src;
        t_hold           hold;
        logic            last;
        logic            jump;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic            go;
        logic [PC_W-1:0] pc;
    } t_start;

    function automatic t_uword mk(input t_op op, input logic en, input logic rs,
                                  input t_src src, input t_hold hold, input logic last,
                                  input logic jump, input t_cond cond,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.en     = en;
        w.rs     = rs;
        w.src    = src;
        w.hold   = hold;
        w.last   = last;
        w.jump   = jump;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword uop(input logic [PC_W-1:0] pc);
        t_uword w;
        w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD, HOLD_SETTLE, 1'b1, 1'b0, CD_NONE, PC_INIT);
        unique case (pc)
            5'd0:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_POWER,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd1:  w = mk(OP_PHASE, 1'b1, 1'b0, SRC_FS,    HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd2:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd3:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_GAP,    1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd4:  w = mk(OP_PHASE, 1'b1, 1'b0, SRC_DC,    HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd5:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd6:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_GAP,    1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd7:  w = mk(OP_PHASE, 1'b1, 1'b0, SRC_CLR,   HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd8:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd9:  w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b1, 1'b0, CD_NONE,
                          PC_INIT);
            5'd10: w = mk(OP_PHASE, 1'b1, 1'b1, SRC_DATA,  HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd11: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b1, 1'b0, CD_NONE,
                          PC_INIT);
            5'd12: w = mk(OP_PHASE, 1'b1, 1'b0, SRC_DATA,  HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd13: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b1, 1'b0, CD_NONE,
                          PC_INIT);
            5'd14: w = mk(OP_PHASE, 1'b1, 1'b0, SRC_POS,   HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd15: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b1, 1'b0, CD_NONE,
                          PC_INIT);
            5'd16: w = mk(OP_PHASE, 1'b1, 1'b0, SRC_POS,   HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd17: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b1, CD_NONE,
                          PC_WR_DATA);
            5'd18: w = mk(OP_MUL,   1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd19: w = mk(OP_DIGIT, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b0, 1'b1, CD_QUOT_NZ,
                          PC_NUMBER);
            5'd20: w = mk(OP_PHASE, 1'b1, 1'b1, SRC_DIGIT, HOLD_PULSE,  1'b0, 1'b0, CD_NONE,
                          PC_INIT);
            5'd21: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD,  HOLD_SETTLE, 1'b1, 1'b1, CD_IDX_NZ,
                          PC_NUM_EMIT);
            default: w = mk(OP_PHASE, 1'b0, 1'b0, SRC_HELD, HOLD_SETTLE, 1'b1, 1'b0, CD_NONE,
                            PC_INIT);
        endcase
        return w;
    endfunction

    function automatic t_start start_pc(input t_action act, input logic [1:0] row);
        t_start s;
        s.go = 1'b1;
        s.pc = PC_INIT;
        unique case (act)
            ACT_INIT:    s.pc = PC_INIT;
            ACT_WR_DATA: s.pc = PC_WR_DATA;
            ACT_WR_CMD:  s.pc = PC_WR_CMD;
            ACT_SET_POS: begin
                s.pc = PC_SET_POS;
                s.go = (row[1] == 1'b0);
            end
            ACT_DATA_POS: begin
                s.pc = PC_DATA_POS;
                s.go = (row[1] == 1'b0);
            end
            ACT_NUMBER:  s.pc = PC_NUMBER;
            default:     s.go = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/char_lcd_write_sequencer_core.sv
// Character LCD write sequencer: microcoded phase generator for an 8-bit LCD bus.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser action, tdata fields
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata phase levels, tlast last phase
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
//  One request is taken per run; a phase step is made whenever the output slot is free.
//  Phases per request: init 10, writes 2, data at position 4; a number first runs a multiply
//  and a digit step per digit for the divide-by-ten unit, then 2 phases per digit (up to 10 digits).
//  Reset puts the timing and init registers at their defaults; no clearing pass.
//  A full output register stalls the step counter on phase steps only.
`default_nettype none

module char_lcd_write_sequencer_core
    import clws_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] data_byte, [9:8] row, [15:10] column, [47:16] number
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] action
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] reg_select, [1] read_not_write, [2] enable_level, [10:3] bus_value,
    // [26:11] hold_us, [31:27] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state                 r_state, n_state;
    logic [PC_W-1:0]        r_pc, n_pc;
    logic [7:0]             r_pulse_us;
    logic [15:0]            r_settle_us;
    logic [7:0]             r_fs_cmd;
    logic [7:0]             r_dc_cmd;
    logic                   r_rs_now, n_rs_now;
    logic [7:0]             r_bus_now, n_bus_now;
    logic [7:0]             r_data_byte, n_data_byte;
    logic [7:0]             r_pos_byte, n_pos_byte;
    logic [31:0]            r_num, n_num;
    logic [QUOT_W-1:0]      r_quot, n_quot;
    logic [DIGIT_IDX_W-1:0] r_nd, n_nd;
    logic [DIGIT_IDX_W-1:0] r_idx, n_idx;
    logic [3:0]             r_digits [MAX_DIGITS];
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_rs, n_out_rs;
    logic                   r_out_en, n_out_en;
    logic [7:0]             r_out_bus, n_out_bus;
    logic [15:0]            r_out_hold, n_out_hold;
    logic                   r_out_last, n_out_last;

    t_uword      w_uw;
    t_start      w_start;
    logic        w_out_free;
    logic        w_step;
    logic        w_cond_ok;
    logic        w_taken;
    logic        w_dig_we;
    logic [63:0] w_prod;
    logic [31:0] w_q_x10;
    logic [31:0] w_rem_full;
    logic [7:0]  w_byte;
    logic [15:0] w_hold;

    assign w_uw       = uop(r_pc);
    assign w_start    = start_pc(t_action'(s_axis_tuser), s_axis_tdata[9:8]);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_step     = (r_state == ST_RUN) && ((w_uw.op != OP_PHASE) || w_out_free);
    assign w_prod     = {32'd0, r_num} * {32'd0, DIV10_RECIP};
    assign w_q_x10    = {r_quot, 3'b000} + {2'b00, r_quot, 1'b0};
    assign w_rem_full = r_num - w_q_x10;
    assign w_dig_we   = w_step && (w_uw.op == OP_DIGIT);
    assign w_taken    = w_uw.jump && w_cond_ok;

    always_comb begin
        case (w_uw.cond)
            CD_QUOT_NZ: w_cond_ok = (r_quot != '0);
            CD_IDX_NZ:  w_cond_ok = (r_idx != '0);
            default:    w_cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        case (w_uw.src)
            SRC_FS:    w_byte = r_fs_cmd;
            SRC_DC:    w_byte = r_dc_cmd;
            SRC_CLR:   w_byte = CMD_CLEAR;
            SRC_DATA:  w_byte = r_data_byte;
            SRC_POS:   w_byte = r_pos_byte;
            SRC_DIGIT: w_byte = {ASCII_DIGIT_HI, r_digits[r_idx]};
            default:   w_byte = r_bus_now;
        endcase
    end

    always_comb begin
        case (w_uw.hold)
            HOLD_POWER: w_hold = POWER_UP_WAIT_US;
            HOLD_GAP:   w_hold = INIT_GAP_US;
            HOLD_PULSE: w_hold = (r_pulse_us == '0) ? 16'd1 : {8'd0, r_pulse_us};
            default:    w_hold = (r_settle_us == '0) ? 16'd1 : r_settle_us;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_rs_now    = r_rs_now;
        n_bus_now   = r_bus_now;
        n_data_byte = r_data_byte;
        n_pos_byte  = r_pos_byte;
        n_num       = r_num;
        n_quot      = r_quot;
        n_nd        = r_nd;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_rs    = r_out_rs;
        n_out_en    = r_out_en;
        n_out_bus   = r_out_bus;
        n_out_hold  = r_out_hold;
        n_out_last  = r_out_last;

        if ((r_state == ST_IDLE) && s_axis_tvalid) begin
            n_data_byte = s_axis_tdata[7:0];
            n_pos_byte  = {(s_axis_tdata[8] ? ROW1_BASE_HI : ROW0_BASE_HI),
                           s_axis_tdata[15:10]};
            n_num       = s_axis_tdata[47:16];
            n_nd        = '0;
            n_pc        = w_start.pc;
            if (w_start.go) begin
                n_state = ST_RUN;
            end
        end

        if (w_step) begin
            n_pc = w_taken ? w_uw.target : PC_W'(r_pc + 1'b1);
            unique case (w_uw.op)
                OP_PHASE: begin
                    n_out_valid = 1'b1;
                    n_out_en    = w_uw.en;
                    n_out_hold  = w_hold;
                    n_out_last  = w_uw.last && !w_taken;
                    if (w_uw.src == SRC_HELD) begin
                        n_out_rs  = r_rs_now;
                        n_out_bus = r_bus_now;
                    end else begin
                        n_out_rs  = w_uw.rs;
                        n_out_bus = w_byte;
                        n_rs_now  = w_uw.rs;
                        n_bus_now = w_byte;
                    end
                    if (w_uw.last && !w_taken) begin
                        n_state = ST_IDLE;
                    end
                    if ((w_uw.cond == CD_IDX_NZ) && w_taken) begin
                        n_idx = DIGIT_IDX_W'(r_idx - 1'b1);
                    end
                end
                OP_MUL: begin
                    n_quot = w_prod[63:35];
                end
                OP_DIGIT: begin
                    n_num = {3'b000, r_quot};
                    n_nd  = DIGIT_IDX_W'(r_nd + 1'b1);
                    if (!w_taken) begin
                        n_idx = r_nd;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= PC_INIT;
            r_pulse_us  <= RST_PULSE_US;
            r_settle_us <= RST_SETTLE_US;
            r_fs_cmd    <= RST_FS_CMD;
            r_dc_cmd    <= RST_DC_CMD;
            r_rs_now    <= 1'b0;
            r_bus_now   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_rs_now    <= n_rs_now;
            r_bus_now   <= n_bus_now;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PULSE_WIDTH: r_pulse_us  <= i_cfg_data[7:0];
                    CFG_SETTLE:      r_settle_us <= i_cfg_data;
                    CFG_FUNC_SET:    r_fs_cmd    <= i_cfg_data[7:0];
                    CFG_DISP_CTRL:   r_dc_cmd    <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_byte <= n_data_byte;
        r_pos_byte  <= n_pos_byte;
        r_num       <= n_num;
        r_quot      <= n_quot;
        r_nd        <= n_nd;
        r_idx       <= n_idx;
        r_out_rs    <= n_out_rs;
        r_out_en    <= n_out_en;
        r_out_bus   <= n_out_bus;
        r_out_hold  <= n_out_hold;
        r_out_last  <= n_out_last;
        if (w_dig_we) begin
            r_digits[r_nd] <= w_rem_full[3:0];
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'd0, r_out_hold, r_out_bus, r_out_en, 1'b0, r_out_rs};

endmodule

`default_nettype wire

// File: rtl/clws_checker.sv
// Port-level checker for the character LCD write sequencer, with its bind.
`default_nettype none
`include "assert_macros.svh"

module clws_checker
    import clws_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast
);

    `CLWS_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output request dropped while stalled")
    `CLWS_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "output request changed while stalled")
    `CLWS_ASSERT_IMPL(a_busy_mid_run, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input ready before the last phase")
    `CLWS_ASSERT_IMPL(a_strobe_not_last, m_axis_tvalid && m_axis_tdata[2], !m_axis_tlast, "enable-high phase marked last")

endmodule

bind char_lcd_write_sequencer_core clws_checker u_clws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for char_lcd_write_sequencer_core against predicted LCD phases.
`default_nettype none

module testbench;
    import clws_pkg::*;

    localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
    localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;
    localparam logic [7:0]  PULSE_DEFAULT = 8'd10;
    localparam logic [15:0] SETTLE_DEFAULT = 16'd2000;
    localparam logic [7:0]  FUNC_DEFAULT  = 8'h38;
    localparam logic [7:0]  DISP_DEFAULT  = 8'h0C;
    localparam logic [7:0]  CLEAR_CMD     = 8'h01;
    localparam logic [15:0] POWER_UP_US   = 16'd40000;
    localparam logic [15:0] INIT_GAP      = 16'd100;
    localparam logic [7:0]  ROW0_CMD      = 8'd128;
    localparam logic [7:0]  ROW1_CMD      = 8'd192;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam int          QUIET_CYCLES  = 64;

    // matches {m_axis_tlast, m_axis_tdata}
    typedef struct packed {
        logic        last;
        logic [4:0]  pad;
        logic [15:0] hold;
        logic [7:0]  bus;
        logic        en;
        logic        rw;
        logic        rs;
    } t_lcd_phase;

    class t_phase_board;
        logic [7:0]  pulse_us;
        logic [15:0] settle_us;
        logic [7:0]  func_set;
        logic [7:0]  disp_ctrl;
        logic        rs_level;
        logic [7:0]  bus_level;
        t_lcd_phase  phases_due[$];
        int          failures;

        function new();
            pulse_us  = PULSE_DEFAULT;
            settle_us = SETTLE_DEFAULT;
            func_set  = FUNC_DEFAULT;
            disp_ctrl = DISP_DEFAULT;
            rs_level  = 1'b0;
            bus_level = 8'h00;
            failures  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PULSE_WIDTH: pulse_us  = val[7:0];
                CFG_SETTLE:      settle_us = val;
                CFG_FUNC_SET:    func_set  = val[7:0];
                CFG_DISP_CTRL:   disp_ctrl = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] nonzero16(logic [15:0] v);
            return (v == 16'd0) ? 16'd1 : v;
        endfunction

        function void add_phase(logic rs, logic en, logic [7:0] bus, logic [15:0] hold);
            t_lcd_phase ph;
            ph      = '0;
            ph.rs   = rs;
            ph.en   = en;
            ph.bus  = bus;
            ph.hold = hold;
            phases_due.push_back(ph);
        endfunction

        function void add_gap(logic [15:0] hold);
            add_phase(rs_level, 1'b0, bus_level, hold);
        endfunction

        function void add_write(logic rs, logic [7:0] val);
            rs_level  = rs;
            bus_level = val;
            add_phase(rs, 1'b1, val, nonzero16({8'd0, pulse_us}));
            add_phase(rs, 1'b0, val, nonzero16(settle_us));
        endfunction

        function void note_request(logic [2:0] act, logic [7:0] data, logic [1:0] row,
                                   logic [5:0] col, logic [31:0] num);
            int          first;
            int          nd;
            int          i;
            logic [3:0]  digits[10];
            logic [31:0] rest;
            t_lcd_phase  tail;
            first = phases_due.size();
            case (act)
                ACT_INIT: begin
                    add_gap(POWER_UP_US);
                    add_write(1'b0, func_set);
                    add_gap(INIT_GAP);
                    add_write(1'b0, disp_ctrl);
                    add_gap(INIT_GAP);
                    add_write(1'b0, CLEAR_CMD);
                    add_gap(nonzero16(settle_us));
                end
                ACT_WR_DATA: add_write(1'b1, data);
                ACT_WR_CMD:  add_write(1'b0, data);
                ACT_SET_POS, ACT_DATA_POS: begin
                    if (row[1] == 1'b0) begin
                        add_write(1'b0, (row[0] ? ROW1_CMD : ROW0_CMD) + {2'b00, col});
                        if (act == ACT_DATA_POS)
                            add_write(1'b1, data);
                    end
                end
                ACT_NUMBER: begin
                    rest = num;
                    nd   = 0;
                    do begin
                        digits[nd] = 4'(rest % 10);
                        rest       = rest / 10;
                        nd++;
                    end while (rest != 0 && nd < 10);
                    for (i = nd - 1; i >= 0; i--)
                        add_write(1'b1, CHAR_ZERO + {4'd0, digits[i]});
                end
                default: ;
            endcase
            if (phases_due.size() > first) begin
                tail      = phases_due.pop_back();
                tail.last = 1'b1;
                phases_due.push_back(tail);
            end
        endfunction

        function string show(t_lcd_phase ph);
            return $sformatf("rs=%0b rw=%0b en=%0b bus=%02h hold=%0d last=%0b pad=%0h",
                             ph.rs, ph.rw, ph.en, ph.bus, ph.hold, ph.last, ph.pad);
        endfunction

        function void check_phase(t_lcd_phase seen);
            t_lcd_phase want;
            if (phases_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: phase with none expected: %s", show(seen));
                return;
            end
            want = phases_due.pop_front();
            if (seen.rs !== want.rs || seen.rw !== want.rw || seen.en !== want.en ||
                seen.bus !== want.bus || seen.hold !== want.hold ||
                seen.last !== want.last || seen.pad !== want.pad) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: phase mismatch\n  exp %s\n  got %s", show(want), show(seen));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_len = 0;
    t_phase_board sb;

    char_lcd_write_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAIL char_lcd_write_sequencer_core");
        $finish;
    end

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            m_axis_tready <= 1'b0;
            hold_len = hold_len - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // handshake signals are stable from the falling edge to the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_phase({m_axis_tlast, m_axis_tdata});
    end

    task automatic send_request(input logic [2:0] act, input logic [7:0] data,
                                input logic [1:0] row, input logic [5:0] col,
                                input logic [31:0] num);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {num, col, row, data};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready)
                break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.note_request(act, data, row, col, num);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready)
                break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // 8-bit registers get random upper bits that must be dropped
    task automatic apply_timing(input logic [7:0] pw, input logic [15:0] st,
                                input logic [7:0] fs, input logic [7:0] dc);
        write_reg(CFG_PULSE_WIDTH, {8'($urandom), pw});
        write_reg(CFG_SETTLE, st);
        write_reg(CFG_FUNC_SET, {8'($urandom), fs});
        write_reg(CFG_DISP_CTRL, {8'($urandom), dc});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_phases();
        s_axis_tvalid <= 1'b0;
        while (sb.phases_due.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_request(output bit made);
        int          pick;
        logic [2:0]  act;
        logic [1:0]  row;
        logic [31:0] num;
        pick = $urandom_range(99);
        if (pick < 8)
            act = ACT_INIT;
        else if (pick < 28)
            act = ACT_WR_DATA;
        else if (pick < 43)
            act = ACT_WR_CMD;
        else if (pick < 58)
            act = ACT_SET_POS;
        else if (pick < 75)
            act = ACT_DATA_POS;
        else if (pick < 95)
            act = ACT_NUMBER;
        else
            act = pick[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        row = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1, 0));
        num = ($urandom_range(3) == 0) ? $urandom : ($urandom >> $urandom_range(31));
        made = (act != ACT_SPARE_LO) && (act != ACT_SPARE_HI) &&
               !((act == ACT_SET_POS || act == ACT_DATA_POS) && row[1]);
        send_request(act, 8'($urandom), row, 6'($urandom), num);
    endtask

    task automatic run_block(input int count);
        int done;
        bit made;
        done = 0;
        while (done < count) begin
            random_request(made);
            if (made)
                done++;
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, field extremes, every request kind
        send_request(ACT_INIT,     8'h00, 2'd0, 6'd0,  32'd0);
        send_request(ACT_WR_DATA,  8'h00, 2'd0, 6'd0,  32'd0);
        send_request(ACT_WR_DATA,  8'hFF, 2'd3, 6'd63, 32'hFFFFFFFF);
        send_request(ACT_WR_CMD,   8'h00, 2'd0, 6'd0,  32'd0);
        send_request(ACT_WR_CMD,   8'hFF, 2'd3, 6'd63, 32'hFFFFFFFF);
        send_request(ACT_SET_POS,  8'h00, 2'd0, 6'd0,  32'd0);
        send_request(ACT_SET_POS,  8'hFF, 2'd1, 6'd63, 32'd0);
        send_request(ACT_SET_POS,  8'h12, 2'd2, 6'd1,  32'd0);
        send_request(ACT_SET_POS,  8'h34, 2'd3, 6'd63, 32'd0);
        send_request(ACT_DATA_POS, 8'hA5, 2'd0, 6'd63, 32'd0);
        send_request(ACT_DATA_POS, 8'h5A, 2'd1, 6'd0,  32'd0);
        send_request(ACT_DATA_POS, 8'hFF, 2'd3, 6'd5,  32'd0);
        send_request(ACT_NUMBER,   8'h00, 2'd0, 6'd0,  32'd0);
        send_request(ACT_NUMBER,   8'h00, 2'd0, 6'd0,  32'hFFFFFFFF);
        send_request(ACT_NUMBER,   8'h00, 2'd0, 6'd0,  32'd1000000000);
        send_request(ACT_NUMBER,   8'h00, 2'd0, 6'd0,  32'd9);
        send_request(ACT_NUMBER,   8'h00, 2'd0, 6'd0,  32'd10);
        send_request(ACT_SPARE_LO, 8'h77, 2'd0, 6'd7,  32'd123);
        send_request(ACT_SPARE_HI, 8'h88, 2'd1, 6'd9,  32'd456);
        send_request(ACT_INIT,     8'hFF, 2'd3, 6'd63, 32'hFFFFFFFF);
        drain_phases();

        // no idling; receiver held off at the start so the input backs up
        apply_timing(8'd255, 16'hFFFF, 8'hFF, 8'h00);
        idle_pct  = 0;
        stall_pct = 0;
        hold_len  = 400;
        run_block(56);
        drain_phases();

        apply_timing(8'd0, 16'd0, 8'h00, 8'hFF);
        idle_pct  = 53;
        stall_pct = 0;
        run_block(56);
        drain_phases();

        apply_timing(8'd1, 16'd1, 8'($urandom), 8'($urandom));
        idle_pct  = 0;
        stall_pct = 53;
        run_block(56);
        drain_phases();

        apply_timing(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        idle_pct  = 32;
        stall_pct = 32;
        run_block(56);
        drain_phases();

        if (sb.failures == 0 && sb.phases_due.size() == 0) begin
            $display("PASS char_lcd_write_sequencer_core");
        end else begin
            $display("FAIL char_lcd_write_sequencer_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/clws_pkg.sv
rtl/char_lcd_write_sequencer_core.sv
rtl/clws_checker.sv
verif/testbench.sv
